[hdl/climate_sensor_compensation_defines.svh]
// Assertion macros for the climate sensor compensation block.
// Used by the top level only; holds nothing but macro definitions.
`ifndef CLIMATE_SENSOR_COMPENSATION_DEFINES_SVH
`define CLIMATE_SENSOR_COMPENSATION_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define CSC_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CSC_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

[hdl/csc_pkg.sv]
// Package for the climate sensor compensation block: payload structs,
// status codes, register indexes and constants. No dependencies.
package csc_pkg;
	typedef struct packed {
		logic [1:0]  mode;
		logic [23:0] raw_temperature;
		logic [23:0] raw_pressure;
		logic [15:0] raw_humidity;
	} csc_in_t;

	typedef struct packed {
		logic signed [32:0] reading;
		logic [2:0]         status;
	} csc_out_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_T_OFF    = 3'd1;
	localparam logic [2:0] ST_P_OFF    = 3'd2;
	localparam logic [2:0] ST_H_OFF    = 3'd3;
	localparam logic [2:0] ST_DIV_ZERO = 3'd4;

	localparam logic [2:0] REG_TEMP  = 3'd0;
	localparam logic [2:0] REG_PA    = 3'd1;
	localparam logic [2:0] REG_PB    = 3'd2;
	localparam logic [2:0] REG_PC    = 3'd3;
	localparam logic [2:0] REG_HUM   = 3'd4;

	localparam logic [1:0] MODE_PRESS = 2'd1;
	localparam logic [1:0] MODE_HUM   = 2'd2;

	localparam logic [23:0] RAW_OFF24 = 24'h800000;
	localparam logic [15:0] RAW_OFF16 = 16'h8000;

	// Request and response structs for the 64-bit divider handshake.
	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [63:0] den;
	} csc_div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
	} csc_div_rsp_t;
endpackage

[hdl/csc_divider.sv]
// Iterative signed 64-bit divider, one quotient bit a cycle, truncating.
// Depends on csc_pkg for the request and response structs.
module csc_divider (
	input  logic                  clk,
	input  logic                  arst_n,
	input  csc_pkg::csc_div_req_t req,
	output csc_pkg::csc_div_rsp_t rsp
);
	import csc_pkg::*;

	logic        busy_q;
	logic [6:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] den_q;
	logic        neg_q;
	logic        done_q;
	logic [64:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num[63] ? 64'd0 - req.num : req.num;
			den_q <= req.den[63] ? 64'd0 - req.den : req.den;
			neg_q <= req.num[63] ^ req.den[63];
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = neg_q ? 64'd0 - quo_q : quo_q;
endmodule

[hdl/climate_sensor_compensation.sv]
// Items run through the microcode steps in turn; disabled codes and a zero divisor
// finish earlier, and pressure also passes through the serial divider. Each microcode
// step runs on one shared 32x32 multiplier. One item at a time, ready only when idle,
// so a new item is accepted only after the previous result has been taken.
// Asynchronous active-low reset clears coefficients, fine temperature and control.
// Top level of the climate sensor compensation block; uses csc_pkg,
// csc_divider and the assertion macro header.
`include "climate_sensor_compensation_defines.svh"
module climate_sensor_compensation (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  csc_pkg::csc_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output csc_pkg::csc_out_t out_data,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data
);
	import csc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RUN  = 4'b0010,
		S_DIV  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q;
	logic [5:0] pc_q;
	logic [1:0] ph_q;
	logic [47:0] tc_q, pa_q, pb_q, pcf_q;
	logic [63:0] hc_q;
	logic signed [31:0] fine_q;
	csc_in_t item_q;
	logic signed [63:0] r_q [8];
	logic signed [63:0] mul_a, mul_b, prod;
	logic signed [63:0] mac_q;
	logic [31:0] mx, my;
	logic [63:0] pp;
	logic step_done;
	logic [2:0] dst;
	logic signed [63:0] res;
	logic last;
	logic div_go;
	csc_out_t out_q;
	csc_div_req_t dreq;
	csc_div_rsp_t drsp;
	logic t_off;

	assign t_off = item_q.raw_temperature == RAW_OFF24;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data = out_q;
	assign step_done = (state_q == S_RUN) && (ph_q == 2'd3);

	function automatic logic signed [63:0] sx(input logic [63:0] v, input int w);
		logic [63:0] m;
		m = (64'd1 << w) - 64'd1;
		return v[w-1] ? signed'(v | ~m) : signed'(v & m);
	endfunction

	function automatic logic signed [63:0] clampv(input logic signed [63:0] x,
		input logic signed [63:0] lo, input logic signed [63:0] hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic signed [63:0] h1, h2, h3, h4, h5, h6, adct, adcp, rh;
	assign t1 = {48'd0, tc_q[15:0]};
	assign t2 = sx({16'd0, tc_q} >> 16, 16);
	assign t3 = sx({16'd0, tc_q} >> 32, 16);
	assign p1 = {48'd0, pa_q[15:0]};
	assign p2 = sx({16'd0, pa_q} >> 16, 16);
	assign p3 = sx({16'd0, pa_q} >> 32, 16);
	assign p4 = sx({16'd0, pb_q}, 16);
	assign p5 = sx({16'd0, pb_q} >> 16, 16);
	assign p6 = sx({16'd0, pb_q} >> 32, 16);
	assign p7 = sx({16'd0, pcf_q}, 16);
	assign p8 = sx({16'd0, pcf_q} >> 16, 16);
	assign p9 = sx({16'd0, pcf_q} >> 32, 16);
	assign h1 = {56'd0, hc_q[7:0]};
	assign h2 = sx(hc_q >> 8, 16);
	assign h3 = {56'd0, hc_q[31:24]};
	assign h4 = sx(hc_q >> 32, 12);
	assign h5 = sx(hc_q >> 44, 12);
	assign h6 = sx(hc_q >> 56, 8);
	assign adct = {44'd0, item_q.raw_temperature[23:4]};
	assign adcp = {44'd0, item_q.raw_pressure[23:4]};
	assign rh = {48'd0, item_q.raw_humidity};

	// The low 64 bits of the product are accumulated from three 32x32 partial
	// products in phases 0 to 2; phase 3 of a step uses them.
	assign mx = (ph_q == 2'd2) ? mul_a[63:32] : mul_a[31:0];
	assign my = (ph_q == 2'd1) ? mul_b[63:32] : mul_b[31:0];
	assign pp = {32'd0, mx} * {32'd0, my};
	assign prod = mac_q;

	// Microcode: each step sets the shared multiplier operands and a
	// post-operation into one scratch register.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		dst = 3'd0;
		res = '0;
		last = 1'b0;
		div_go = 1'b0;
		unique case (pc_q)
			6'd0: begin
				mul_a = (adct >>> 3) - 2 * t1; mul_b = t2; dst = 3'd0;
				res = prod >>> 11;
			end
			6'd1: begin
				mul_a = (adct >>> 4) - t1; mul_b = mul_a; dst = 3'd1;
				res = prod >>> 12;
			end
			6'd2: begin
				mul_a = r_q[1]; mul_b = t3; dst = 3'd1;
				res = (prod >>> 14) + r_q[0];
			end
			6'd3: begin
				mul_a = 64'(fine_q) - 64'd128000; mul_b = mul_a; dst = 3'd0;
				res = prod;
			end
			6'd4: begin
				mul_a = r_q[0]; mul_b = p6; dst = 3'd1; res = prod;
			end
			6'd5: begin
				mul_a = 64'(fine_q) - 64'd128000; mul_b = p5; dst = 3'd1;
				res = r_q[1] + (prod <<< 17) + (p4 <<< 35);
			end
			6'd6: begin
				mul_a = r_q[0]; mul_b = p3; dst = 3'd2; res = prod >>> 8;
			end
			6'd7: begin
				mul_a = 64'(fine_q) - 64'd128000; mul_b = p2; dst = 3'd2;
				res = r_q[2] + (prod <<< 12) + (64'sd1 <<< 47);
			end
			6'd8: begin
				mul_a = r_q[2]; mul_b = p1; dst = 3'd2; res = prod >>> 33;
			end
			6'd9: begin
				mul_a = ((64'sd1048576 - adcp) <<< 31) - r_q[1]; mul_b = 64'sd3125;
				dst = 3'd3; res = prod; div_go = 1'b1;
			end
			6'd10: begin
				mul_a = p9; mul_b = r_q[4] >>> 13; dst = 3'd5; res = prod;
			end
			6'd11: begin
				mul_a = r_q[5]; mul_b = r_q[4] >>> 13; dst = 3'd5; res = prod >>> 25;
			end
			6'd12: begin
				mul_a = p8; mul_b = r_q[4]; dst = 3'd6;
				res = clampv(((r_q[4] + r_q[5] + (prod >>> 19)) >>> 8) + (p7 <<< 4),
					64'sd0, 64'sd4294967295);
				last = 1'b1;
			end
			6'd20: begin
				mul_a = 64'(fine_q) - 64'sd76800; mul_b = h5; dst = 3'd0;
				res = ((rh <<< 14) - (h4 <<< 20) - prod + 64'sd16384) >>> 15;
			end
			6'd21: begin
				mul_a = 64'(fine_q) - 64'sd76800; mul_b = h6; dst = 3'd1;
				res = prod >>> 10;
			end
			6'd22: begin
				mul_a = 64'(fine_q) - 64'sd76800; mul_b = h3; dst = 3'd2;
				res = (prod >>> 11) + 64'sd32768;
			end
			6'd23: begin
				mul_a = r_q[1]; mul_b = r_q[2]; dst = 3'd1;
				res = (prod >>> 10) + 64'sd2097152;
			end
			6'd24: begin
				mul_a = r_q[1]; mul_b = h2; dst = 3'd1;
				res = (prod + 64'sd8192) >>> 14;
			end
			6'd25: begin
				mul_a = r_q[0]; mul_b = r_q[1]; dst = 3'd0;
				res = clampv(prod, -64'sd2147483648, 64'sd2147483647);
			end
			6'd26: begin
				mul_a = r_q[0] >>> 15; mul_b = mul_a; dst = 3'd1; res = prod >>> 7;
			end
			6'd27: begin
				mul_a = r_q[1]; mul_b = h1; dst = 3'd0;
				res = clampv(r_q[0] - (prod >>> 4), 64'sd0, 64'sd419430400) >>> 12;
				last = 1'b1;
			end
			6'd30: begin
				mul_a = 64'(fine_q); mul_b = 64'sd5; dst = 3'd0;
				res = clampv((prod + 64'sd128) >>> 8, -64'sd4000, 64'sd8500);
				last = 1'b1;
			end
			default: begin
				last = 1'b1;
			end
		endcase
	end

	assign dreq.start = step_done && div_go && (r_q[2] != 0);
	assign dreq.num = prod;
	assign dreq.den = r_q[2];

	csc_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= '0; pa_q <= '0; pb_q <= '0; pcf_q <= '0; hc_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEMP: tc_q  <= cfg_data[47:0];
				REG_PA:   pa_q  <= cfg_data[47:0];
				REG_PB:   pb_q  <= cfg_data[47:0];
				REG_PC:   pcf_q <= cfg_data[47:0];
				REG_HUM:  hc_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			ph_q <= '0;
			fine_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_RUN;
						pc_q <= (in_data.raw_temperature == RAW_OFF24) ? 6'd3 : 6'd0;
					end
				end
				S_RUN: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						if (pc_q == 6'd2) begin
							fine_q <= res[31:0];
						end
						if (pc_q == 6'd2 || pc_q == 6'd3 && t_off && !(item_q.mode == MODE_PRESS)) begin
							if (item_q.mode == MODE_PRESS) begin
								pc_q <= item_q.raw_pressure == RAW_OFF24 ? 6'd40 : 6'd3;
							end else if (item_q.mode == MODE_HUM) begin
								pc_q <= item_q.raw_humidity == RAW_OFF16 ? 6'd40 : 6'd20;
							end else begin
								pc_q <= t_off ? 6'd40 : 6'd30;
							end
						end else if (pc_q == 6'd3 && item_q.raw_pressure == RAW_OFF24) begin
							pc_q <= 6'd40;
						end else if (pc_q == 6'd9) begin
							if (r_q[2] == 0) begin
								pc_q <= 6'd41;
							end else begin
								state_q <= S_DIV;
							end
						end else if (last) begin
							state_q <= S_OUT;
						end else begin
							pc_q <= pc_q + 6'd1;
						end
					end
				end
				S_DIV: begin
					if (drsp.done) begin
						state_q <= S_RUN;
						pc_q <= 6'd10;
					end
				end
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RUN) begin
			case (ph_q)
				2'd0: mac_q <= pp;
				2'd1, 2'd2: mac_q <= mac_q + {pp[31:0], 32'd0};
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) item_q <= in_data;
		if (step_done) r_q[dst] <= res;
		if (state_q == S_DIV && drsp.done) r_q[4] <= signed'(drsp.quo);
		if (step_done && last) begin
			if (pc_q == 6'd40) begin
				out_q.reading <= '0;
				out_q.status <= item_q.mode == MODE_PRESS ? ST_P_OFF :
					item_q.mode == MODE_HUM ? ST_H_OFF : ST_T_OFF;
			end else if (pc_q == 6'd41) begin
				out_q.reading <= '0;
				out_q.status <= ST_DIV_ZERO;
			end else begin
				out_q.reading <= res[32:0];
				out_q.status <= ST_OK;
			end
		end
	end

	`CSC_ASSERT_IMP(a_ready_idle, clk, arst_n, out_valid, !in_ready)
	`CSC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`CSC_ASSERT_IMP(a_div_only, clk, arst_n, drsp.done, state_q == S_DIV)
endmodule

[dv/climate_sensor_compensation_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the climate sensor compensation block.
// Drives raw conversion words and coefficient writes, predicts readings in-bench.
// Depends on csc_pkg and climate_sensor_compensation.
module climate_sensor_compensation_tb;
	import csc_pkg::*;

	localparam logic [1:0] MODE_TEMP = 2'd0;
	localparam logic [1:0] MODE_THREE = 2'd3;
	localparam int N_RANDOM = 1100;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct {
		csc_in_t    item;
		logic       has_gold;
		logic [32:0] gold_reading;
		logic [2:0] gold_status;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	csc_in_t in_data;
	logic out_valid;
	logic out_ready;
	csc_out_t out_data;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [63:0] cfg_data;

	logic [47:0] temp_coeffs, press_a, press_b, press_c;
	logic [63:0] hum_coeffs;
	logic signed [31:0] fine_temp;
	csc_out_t pending_readings[$];
	int mismatches;
	longint cycles;
	logic long_hold;
	logic rx_enable;

	climate_sensor_compensation dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint sx16(logic [15:0] v);
		return longint'(signed'(v));
	endfunction

	function automatic longint clampl(longint x, longint lo, longint hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	// Signed division truncating toward zero, wrapping the one overflow case.
	function automatic longint div_trunc(longint a, longint b);
		logic [63:0] ma, mb, q;
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		q = ma / mb;
		if ((a < 0) != (b < 0))
			q = -q;
		return longint'(q);
	endfunction

	function automatic void update_fine_temp(logic [23:0] raw);
		longint t1, t2, t3, adc, v1, d, v2;
		t1 = longint'({48'd0, temp_coeffs[15:0]});
		t2 = sx16(temp_coeffs[31:16]);
		t3 = sx16(temp_coeffs[47:32]);
		adc = longint'({44'd0, raw[23:4]});
		v1 = (((adc >>> 3) - 2 * t1) * t2) >>> 11;
		d = (adc >>> 4) - t1;
		v2 = (((d * d) >>> 12) * t3) >>> 14;
		fine_temp = 32'(v1 + v2);
	endfunction

	function automatic logic [2:0] pressure_pa(logic [23:0] raw, output longint res);
		longint p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, a, b;
		p1 = longint'({48'd0, press_a[15:0]});
		p2 = sx16(press_a[31:16]);
		p3 = sx16(press_a[47:32]);
		p4 = sx16(press_b[15:0]);
		p5 = sx16(press_b[31:16]);
		p6 = sx16(press_b[47:32]);
		p7 = sx16(press_c[15:0]);
		p8 = sx16(press_c[31:16]);
		p9 = sx16(press_c[47:32]);
		res = 0;
		v1 = longint'(fine_temp) - 128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) <<< 17);
		v2 = v2 + (p4 <<< 35);
		v1 = (((v1 * v1 * p3) >>> 8)) + ((v1 * p2) <<< 12);
		v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
		if (v1 == 0)
			return ST_DIV_ZERO;
		p = 1048576 - longint'({44'd0, raw[23:4]});
		p = div_trunc(((p <<< 31) - v2) * 3125, v1);
		a = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
		b = (p8 * p) >>> 19;
		p = ((p + a + b) >>> 8) + (p7 <<< 4);
		res = clampl(p, 0, 64'sd4294967295);
		return ST_OK;
	endfunction

	function automatic longint humidity_rh(logic [15:0] raw);
		longint h1, h2, h3, h4, h5, h6, v, x, y, r, s;
		h1 = longint'({56'd0, hum_coeffs[7:0]});
		h2 = sx16(hum_coeffs[23:8]);
		h3 = longint'({56'd0, hum_coeffs[31:24]});
		h4 = longint'(signed'(hum_coeffs[43:32]));
		h5 = longint'(signed'(hum_coeffs[55:44]));
		h6 = longint'(signed'(hum_coeffs[63:56]));
		v = longint'(fine_temp) - 76800;
		x = (longint'({48'd0, raw}) * 16384 - h4 * 1048576 - h5 * v + 16384) >>> 15;
		y = ((((v * h6) >>> 10) * (((v * h3) >>> 11) + 32768)) >>> 10) + 2097152;
		y = (y * h2 + 8192) >>> 14;
		r = clampl(x * y, -64'sd2147483648, 64'sd2147483647);
		s = r >>> 15;
		r = r - ((((s * s) >>> 7) * h1) >>> 4);
		r = clampl(r, 0, 419430400);
		return r >>> 12;
	endfunction

	function automatic csc_out_t compensate(csc_in_t it);
		csc_out_t o;
		longint rd;
		logic t_off;
		t_off = it.raw_temperature == RAW_OFF24;
		rd = 0;
		o.status = ST_OK;
		if (!t_off)
			update_fine_temp(it.raw_temperature);
		if (it.mode == MODE_PRESS) begin
			if (it.raw_pressure == RAW_OFF24)
				o.status = ST_P_OFF;
			else
				o.status = pressure_pa(it.raw_pressure, rd);
		end else if (it.mode == MODE_HUM) begin
			if (it.raw_humidity == RAW_OFF16)
				o.status = ST_H_OFF;
			else
				rd = humidity_rh(it.raw_humidity);
		end else begin
			if (t_off)
				o.status = ST_T_OFF;
			else
				rd = clampl((longint'(fine_temp) * 5 + 128) >>> 8, -4000, 8500);
		end
		o.reading = rd[32:0];
		return o;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TEMP: temp_coeffs = val[47:0];
			REG_PA:   press_a = val[47:0];
			REG_PB:   press_b = val[47:0];
			REG_PC:   press_c = val[47:0];
			REG_HUM:  hum_coeffs = val;
			default: ;
		endcase
	endtask

	// Offers one item; the burst gap is applied by the caller.
	task automatic send_item(csc_in_t it, output csc_out_t predicted);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = compensate(it);
		pending_readings.push_back(predicted);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain_and_settle();
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic load_coeffs(int setting);
		logic [63:0] r;
		case (setting)
			0: begin
				// Typical calibration values.
				write_reg(REG_TEMP, {16'sd50, 16'sd26435, 16'd27504});
				write_reg(REG_PA, {16'sd3024, -16'sd10685, 16'd36477});
				write_reg(REG_PB, {16'sd140, -16'sd7, 16'sd2855});
				write_reg(REG_PC, {16'sd4285, -16'sd10230, 16'sd15500});
				write_reg(REG_HUM, {8'sd30, 12'sd50, 12'sd320, 8'd0, 16'sd361, 8'd75});
			end
			1: begin
				for (int i = 0; i < 5; i++)
					write_reg(i[2:0], 64'hFFFF_FFFF_FFFF_FFFF);
			end
			2: begin
				write_reg(REG_TEMP, {16'h8000, 16'h7FFF, 16'h0000});
				write_reg(REG_PA, {16'h7FFF, 16'h8000, 16'hFFFF});
				write_reg(REG_PB, {16'h8000, 16'h7FFF, 16'h8000});
				write_reg(REG_PC, {16'h7FFF, 16'h8000, 16'h7FFF});
				write_reg(REG_HUM, 64'h7F_7FF_800_FF_8000_00);
			end
			default: begin
				for (int i = 0; i < 5; i++) begin
					r = {$urandom, $urandom};
					write_reg(i[2:0], r);
				end
			end
		endcase
	endtask

	function automatic csc_in_t random_item();
		csc_in_t it;
		int sel;
		it.mode = 2'($urandom_range(0, 3));
		it.raw_temperature = 24'($urandom);
		it.raw_pressure = 24'($urandom);
		it.raw_humidity = 16'($urandom);
		sel = $urandom_range(0, 99);
		if (sel < 60) begin
			it.raw_temperature = 24'($urandom_range(24'h600000, 24'h900000));
			it.raw_pressure = 24'($urandom_range(24'h400000, 24'h700000));
			it.raw_humidity = 16'($urandom_range(16'h5000, 16'h8800));
		end else if (sel < 65)
			it.raw_temperature = RAW_OFF24;
		else if (sel < 70)
			it.raw_pressure = RAW_OFF24;
		else if (sel < 75)
			it.raw_humidity = RAW_OFF16;
		return it;
	endfunction

	// Output checker.
	always @(posedge clk) begin
		csc_out_t gold;
		if (arst_n && out_valid && out_ready) begin
			if (pending_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: reading=%0d status=%0d",
						out_data.reading, out_data.status);
			end else begin
				gold = pending_readings.pop_front();
				if (gold.reading !== out_data.reading || gold.status !== out_data.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected reading=%0d status=%0d, got reading=%0d status=%0d",
							gold.reading, gold.status, out_data.reading, out_data.status);
				end
			end
		end
	end

	// Receiver stall pattern, with an optional long hold-off.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (long_hold || !rx_enable) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= (cycles % 64 < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		stim_row_t rows[$];
		csc_out_t predicted;
		csc_in_t it;
		int burst;
		mismatches = 0;
		cycles = 0;
		long_hold = 1'b0;
		rx_enable = 1'b1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		temp_coeffs = '0;
		press_a = '0;
		press_b = '0;
		press_c = '0;
		hum_coeffs = '0;
		fine_temp = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// After reset all coefficients are zero: temperature reads 0 and pressure
		// has a zero divisor.
		rows.push_back('{'{MODE_TEMP, 24'h7A1200, 24'h5A0000, 16'h6A00}, 1'b1, 33'd0, ST_OK});
		rows.push_back('{'{MODE_PRESS, 24'h7A1200, 24'h5A0000, 16'h6A00}, 1'b1, 33'd0,
			ST_DIV_ZERO});
		rows.push_back('{'{MODE_TEMP, RAW_OFF24, 24'h0, 16'h0}, 1'b1, 33'd0, ST_T_OFF});
		rows.push_back('{'{MODE_PRESS, 24'h0, RAW_OFF24, 16'h0}, 1'b1, 33'd0, ST_P_OFF});
		rows.push_back('{'{MODE_HUM, 24'hFFFFFF, 24'h0, RAW_OFF16}, 1'b1, 33'd0, ST_H_OFF});
		rows.push_back('{'{MODE_HUM, 24'h000000, 24'hFFFFFF, 16'hFFFF}, 1'b0, 33'd0, ST_OK});
		rows.push_back('{'{MODE_THREE, 24'hFFFFFF, 24'hFFFFFF, 16'h0000}, 1'b0, 33'd0, ST_OK});
		foreach (rows[i]) begin
			send_item(rows[i].item, predicted);
			if (rows[i].has_gold && (predicted.reading !== rows[i].gold_reading ||
				predicted.status !== rows[i].gold_status)) begin
				mismatches++;
				$display("Table row %0d disagrees with prediction", i);
			end
		end
		drain_and_settle();

		// Directed rows under typical, all-ones and extreme coefficients.
		for (int s = 0; s < 3; s++) begin
			load_coeffs(s);
			rows.delete();
			rows.push_back('{'{MODE_TEMP, 24'h000000, 24'h0, 16'h0}, 1'b0, 33'd0, ST_OK});
			rows.push_back('{'{MODE_TEMP, 24'hFFFFFF, 24'h0, 16'h0}, 1'b0, 33'd0, ST_OK});
			rows.push_back('{'{MODE_PRESS, 24'h7E0000, 24'h000000, 16'h0}, 1'b0, 33'd0, ST_OK});
			rows.push_back('{'{MODE_PRESS, 24'h7E0000, 24'hFFFFFF, 16'h0}, 1'b0, 33'd0, ST_OK});
			rows.push_back('{'{MODE_PRESS, RAW_OFF24, 24'h5A0000, 16'h0}, 1'b0, 33'd0, ST_OK});
			rows.push_back('{'{MODE_HUM, 24'h7E0000, 24'h0, 16'h0000}, 1'b0, 33'd0, ST_OK});
			rows.push_back('{'{MODE_HUM, RAW_OFF24, 24'h0, 16'hFFFF}, 1'b0, 33'd0, ST_OK});
			foreach (rows[i])
				send_item(rows[i].item, predicted);
			drain_and_settle();
		end

		// Random part in phases, each under a new coefficient setting.
		for (int ph = 0; ph < 6; ph++) begin
			load_coeffs(ph == 0 ? 0 : (ph == 5 ? 2 : 3));
			if (ph == 1)
				fork
					begin
						long_hold = 1'b1;
						repeat (600) @(posedge clk);
						long_hold = 1'b0;
					end
				join_none
			for (int n = 0; n < N_RANDOM / 6; ) begin
				burst = $urandom_range(1, 12);
				for (int b = 0; b < burst && n < N_RANDOM / 6; b++, n++) begin
					it = random_item();
					send_item(it, predicted);
				end
				if ($urandom_range(0, 2) == 0)
					repeat ($urandom_range(1, 90)) @(negedge clk);
			end
			drain_and_settle();
		end

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
